### design/fsdr_pkg.sv
// Shared widths and fixed-point constants for the Fresnel reflectance block.
`timescale 1ns / 1ps
package fsdr_pkg;
   localparam int COS_W   = 16;
   localparam int ETA_W   = 16;
   localparam int REFL_W  = 16;
   localparam int FRAC_W  = 28;
   localparam logic signed [COS_W-1:0] COS_ONE = 16'sd16384;
   localparam logic [REFL_W-1:0]       REFL_ONE = 16'd32768;
endpackage

### design/fsdr_if.sv
// Valid/ready channel interfaces for the request and response sides.
`timescale 1ns / 1ps
interface fsdr_req_if;
   logic                              valid;
   logic                              ready;
   logic signed [fsdr_pkg::COS_W-1:0] cos_incident;
   logic [fsdr_pkg::ETA_W-1:0]        eta_incident;
   logic [fsdr_pkg::ETA_W-1:0]        eta_transmitted;
   modport source (output valid, cos_incident, eta_incident, eta_transmitted, input ready);
   modport sink (input valid, cos_incident, eta_incident, eta_transmitted, output ready);
endinterface

interface fsdr_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [fsdr_pkg::REFL_W-1:0] reflectance;
   logic                        total_internal;
   modport source (output valid, reflectance, total_internal, input ready);
   modport sink (input valid, reflectance, total_internal, output ready);
endinterface

### design/fsdr_div_pipe.sv
// Pipelined restoring divider, one quotient bit per register stage.
`timescale 1ns / 1ps
module fsdr_div_pipe #(
   parameter int DEN_W  = 32,
   parameter int QUO_W  = 28,
   parameter int SIDE_W = 1
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  logic                     in_valid,
   input  logic [DEN_W+QUO_W-1:0]   in_num,
   input  logic [DEN_W-1:0]         in_den,
   input  logic [SIDE_W-1:0]        in_side,
   output logic                     out_valid,
   output logic [QUO_W-1:0]         out_quo,
   output logic [SIDE_W-1:0]        out_side
);
   // The upper numerator part must be below the divisor for a valid quotient.
   logic              v_ff    [QUO_W];
   logic [DEN_W-1:0]  rem_ff  [QUO_W];
   logic [QUO_W-1:0]  lq_ff   [QUO_W];
   logic [DEN_W-1:0]  den_ff  [QUO_W];
   logic [SIDE_W-1:0] side_ff [QUO_W];

   for (genvar k = 0; k < QUO_W; k++) begin : g_stage
      logic              pv;
      logic [DEN_W-1:0]  prem;
      logic [QUO_W-1:0]  plq;
      logic [DEN_W-1:0]  pden;
      logic [SIDE_W-1:0] pside;
      logic [DEN_W:0]    trial;
      logic              take;
      logic [DEN_W-1:0]  rem_in;
      logic [QUO_W-1:0]  lq_in;

      if (k == 0) begin : g_first
         assign pv    = in_valid;
         assign prem  = in_num[DEN_W+QUO_W-1:QUO_W];
         assign plq   = in_num[QUO_W-1:0];
         assign pden  = in_den;
         assign pside = in_side;
      end else begin : g_next
         assign pv    = v_ff[k-1];
         assign prem  = rem_ff[k-1];
         assign plq   = lq_ff[k-1];
         assign pden  = den_ff[k-1];
         assign pside = side_ff[k-1];
      end

      assign trial  = {prem, plq[QUO_W-1]};
      assign take   = trial >= {1'b0, pden};
      assign rem_in = take ? DEN_W'(trial - {1'b0, pden}) : trial[DEN_W-1:0];
      assign lq_in  = {plq[QUO_W-2:0], take};

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en) begin
            v_ff[k] <= pv;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in;
            lq_ff[k]   <= lq_in;
            den_ff[k]  <= pden;
            side_ff[k] <= pside;
         end
      end
   end

   assign out_valid = v_ff[QUO_W-1];
   assign out_quo   = lq_ff[QUO_W-1];
   assign out_side  = side_ff[QUO_W-1];
endmodule

### design/fsdr_sqrt_pipe.sv
// Pipelined integer square root, one root bit per register stage.
`timescale 1ns / 1ps
module fsdr_sqrt_pipe #(
   parameter int ROOT_W = 15,
   parameter int SIDE_W = 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  logic [2*ROOT_W-1:0]   in_val,
   input  logic [SIDE_W-1:0]     in_side,
   output logic                  out_valid,
   output logic [ROOT_W-1:0]     out_root,
   output logic [SIDE_W-1:0]     out_side
);
   logic                v_ff    [ROOT_W];
   logic [2*ROOT_W-1:0] rem_ff  [ROOT_W];
   logic [ROOT_W-1:0]   root_ff [ROOT_W];
   logic [SIDE_W-1:0]   side_ff [ROOT_W];

   for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
      localparam int BIT = ROOT_W - 1 - k;
      logic                pv;
      logic [2*ROOT_W-1:0] prem;
      logic [ROOT_W-1:0]   proot;
      logic [SIDE_W-1:0]   pside;
      logic [2*ROOT_W:0]   inc;
      logic                take;
      logic [2*ROOT_W-1:0] rem_in;
      logic [ROOT_W-1:0]   root_in;

      if (k == 0) begin : g_first
         assign pv    = in_valid;
         assign prem  = in_val;
         assign proot = '0;
         assign pside = in_side;
      end else begin : g_next
         assign pv    = v_ff[k-1];
         assign prem  = rem_ff[k-1];
         assign proot = root_ff[k-1];
         assign pside = side_ff[k-1];
      end

      // Growing the root by 2^BIT raises its square by root*2^(BIT+1) + 2^(2*BIT).
      assign inc     = ({(ROOT_W+1)'(0), proot} << (BIT + 1))
                     + ((2*ROOT_W+1)'(1) << (2 * BIT));
      assign take    = {1'b0, prem} >= inc;
      assign rem_in  = take ? (2*ROOT_W)'({1'b0, prem} - inc) : prem;
      assign root_in = proot | (take ? (ROOT_W'(1) << BIT) : '0);

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en) begin
            v_ff[k] <= pv;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            side_ff[k] <= pside;
         end
      end
   end

   assign out_valid = v_ff[ROOT_W-1];
   assign out_root  = root_ff[ROOT_W-1];
   assign out_side  = side_ff[ROOT_W-1];
endmodule

### design/fresnel_dielectric_reflectance.sv
// Top level of the unpolarized dielectric Fresnel reflectance pipeline.
//
// This block takes one transfer per cycle carrying a Q2.14 incident cosine and two
// Q4.12 refractive indices, and returns one transfer per item with the Q1.15
// reflectance and a total internal reflection flag. Each item passes from request
// transfer to response valid through four setup stages (clamp and index swap, the
// squares, the wide product for the transmitted sine test, and the test itself), a
// 28-stage divider for the transmitted cosine squared, one stage to form it, a
// 15-stage square root, two stages of products and sums, a pair of 16-stage dividers
// for the two amplitudes, and two stages that square, average and saturate. The
// whole pipeline advances together; it stops only when a finished response is held
// in the output register and the sink is not ready, so throughput is one item per
// cycle whenever the response side keeps up. Items are independent and the block
// has no configuration and no state beyond the pipeline itself.
`timescale 1ns / 1ps
module fresnel_dielectric_reflectance (
   input  logic        clock,
   input  logic        reset,
   fsdr_req_if.sink    req_chan,
   fsdr_rsp_if.source  rsp_chan
);
   localparam int ETA_W = fsdr_pkg::ETA_W;
   localparam int FRAC_W = fsdr_pkg::FRAC_W;
   localparam int C_W = 15;
   localparam int SIDE1_W = 1 + 2 * ETA_W + C_W;

   logic en;
   logic out_v_ff;

   // Everything advances unless the output register holds an unaccepted response.
   assign en = !out_v_ff || rsp_chan.ready;
   assign req_chan.ready = en;

   // Stage 0: clamp the cosine, swap indices when the light is leaving.
   logic signed [fsdr_pkg::COS_W-1:0] cos_cl;
   logic [C_W-1:0]   cmag;
   logic             enter;
   logic             v0_ff;
   logic [C_W-1:0]   c0_ff;
   logic [ETA_W-1:0] ei0_ff, et0_ff;

   always_comb begin
      cos_cl = req_chan.cos_incident;
      if (cos_cl > fsdr_pkg::COS_ONE) begin
         cos_cl = fsdr_pkg::COS_ONE;
      end
      if (cos_cl < -fsdr_pkg::COS_ONE) begin
         cos_cl = -fsdr_pkg::COS_ONE;
      end
      enter = cos_cl > 0;
      cmag  = enter ? cos_cl[C_W-1:0] : C_W'(-cos_cl);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c0_ff  <= cmag;
         ei0_ff <= enter ? req_chan.eta_incident : req_chan.eta_transmitted;
         et0_ff <= enter ? req_chan.eta_transmitted : req_chan.eta_incident;
      end
   end

   // Stage 1: squares of the indices and the incident sine squared in Q28.
   logic [2*C_W-1:0]   cc;
   logic               v1_ff;
   logic [FRAC_W:0]    s2_1_ff;
   logic [2*ETA_W-1:0] ei2_1_ff, et2_1_ff;
   logic [C_W-1:0]     c1_ff;
   logic [ETA_W-1:0]   ei1_ff, et1_ff;

   assign cc = {{C_W{1'b0}}, c0_ff} * {{C_W{1'b0}}, c0_ff};

   always_ff @(posedge clock) begin
      if (en) begin
         s2_1_ff  <= (FRAC_W+1)'((2*C_W)'(1) << FRAC_W) - (FRAC_W+1)'(cc);
         ei2_1_ff <= {{ETA_W{1'b0}}, ei0_ff} * {{ETA_W{1'b0}}, ei0_ff};
         et2_1_ff <= {{ETA_W{1'b0}}, et0_ff} * {{ETA_W{1'b0}}, et0_ff};
         c1_ff    <= c0_ff;
         ei1_ff   <= ei0_ff;
         et1_ff   <= et0_ff;
      end
   end

   // Stage 2: the scaled transmitted sine squared, ei^2 * s2.
   localparam int LHS_W = 2 * ETA_W + FRAC_W + 1;
   logic               v2_ff;
   logic [LHS_W-1:0]   lhs2_ff;
   logic [2*ETA_W-1:0] et2_2_ff;
   logic [C_W-1:0]     c2_ff;
   logic [ETA_W-1:0]   ei2_ff, et2_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         lhs2_ff  <= {{(FRAC_W+1){1'b0}}, ei2_1_ff} * {{(2*ETA_W){1'b0}}, s2_1_ff};
         et2_2_ff <= et2_1_ff;
         c2_ff    <= c1_ff;
         ei2_ff   <= ei1_ff;
         et2_ff   <= et1_ff;
      end
   end

   // Stage 3: total internal reflection test, sin_t >= 1 without rounding.
   logic                    v3_ff;
   logic                    tir3_ff;
   logic [LHS_W-2:0]        lhs3_ff;
   logic [2*ETA_W-1:0]      et2_3_ff;
   logic [C_W-1:0]          c3_ff;
   logic [ETA_W-1:0]        ei3_ff, et3_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         tir3_ff  <= lhs2_ff >= {1'b0, et2_2_ff, {FRAC_W{1'b0}}};
         lhs3_ff  <= lhs2_ff[LHS_W-2:0];
         et2_3_ff <= et2_2_ff;
         c3_ff    <= c2_ff;
         ei3_ff   <= ei2_ff;
         et3_ff   <= et2_ff;
      end
   end

   // Divider: ei^2 * s2 / et^2, a Q28 value below one when light transmits.
   logic               d1_v;
   logic [FRAC_W-1:0]  d1_q;
   logic [SIDE1_W-1:0] d1_side;

   fsdr_div_pipe #(
      .DEN_W (2 * ETA_W),
      .QUO_W (FRAC_W),
      .SIDE_W(SIDE1_W)
   ) u_div_sin (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (v3_ff),
      .in_num   (lhs3_ff),
      .in_den   (et2_3_ff),
      .in_side  ({tir3_ff, ei3_ff, et3_ff, c3_ff}),
      .out_valid(d1_v),
      .out_quo  (d1_q),
      .out_side (d1_side)
   );

   // Stage 4: transmitted cosine squared in Q28.
   logic               v4_ff;
   logic [FRAC_W:0]    ct2_4_ff;
   logic [SIDE1_W-1:0] side4_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         ct2_4_ff <= (FRAC_W+1)'((FRAC_W+1)'(1) << FRAC_W) - {1'b0, d1_q};
         side4_ff <= d1_side;
      end
   end

   // Square root gives the transmitted cosine in Q14.
   logic               sq_v;
   logic [C_W-1:0]     ct;
   logic [SIDE1_W-1:0] sq_side;

   fsdr_sqrt_pipe #(
      .ROOT_W(C_W),
      .SIDE_W(SIDE1_W)
   ) u_sqrt_cos (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (v4_ff),
      .in_val   ({{(2*C_W-FRAC_W-1){1'b0}}, ct2_4_ff}),
      .in_side  (side4_ff),
      .out_valid(sq_v),
      .out_root (ct),
      .out_side (sq_side)
   );

   logic             sq_tir;
   logic [ETA_W-1:0] sq_ei, sq_et;
   logic [C_W-1:0]   sq_c;

   assign {sq_tir, sq_ei, sq_et, sq_c} = sq_side;

   // Stage 5: the four index-cosine products in Q26.
   localparam int PROD_W = ETA_W + C_W;
   logic              v5_ff, tir5_ff;
   logic [PROD_W-1:0] p5_ff, q5_ff, u5_ff, w5_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         p5_ff   <= {{C_W{1'b0}}, sq_et} * {{ETA_W{1'b0}}, sq_c};
         q5_ff   <= {{C_W{1'b0}}, sq_ei} * {{ETA_W{1'b0}}, ct};
         u5_ff   <= {{C_W{1'b0}}, sq_ei} * {{ETA_W{1'b0}}, sq_c};
         w5_ff   <= {{C_W{1'b0}}, sq_et} * {{ETA_W{1'b0}}, ct};
         tir5_ff <= sq_tir;
      end
   end

   // Stage 6: sums and absolute differences of the amplitude terms.
   localparam int SUM_W = PROD_W + 1;
   logic             v6_ff, tir6_ff;
   logic [SUM_W-1:0] sa6_ff, sb6_ff;
   logic [PROD_W-1:0] da6_ff, db6_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         sa6_ff  <= {1'b0, p5_ff} + {1'b0, q5_ff};
         sb6_ff  <= {1'b0, u5_ff} + {1'b0, w5_ff};
         da6_ff  <= (p5_ff > q5_ff) ? p5_ff - q5_ff : q5_ff - p5_ff;
         db6_ff  <= (u5_ff > w5_ff) ? u5_ff - w5_ff : w5_ff - u5_ff;
         tir6_ff <= tir5_ff;
      end
   end

   // Amplitudes |x-y|/(x+y) in Q15, rounded by adding half the divisor.
   localparam int AMP_W = fsdr_pkg::REFL_W;
   localparam int NUM_W = SUM_W + AMP_W;
   logic [NUM_W-1:0] num_a, num_b;

   assign num_a = ({{(AMP_W+1){1'b0}}, da6_ff} << (AMP_W - 1))
                + {{(AMP_W+1){1'b0}}, sa6_ff[SUM_W-1:1]};
   assign num_b = ({{(AMP_W+1){1'b0}}, db6_ff} << (AMP_W - 1))
                + {{(AMP_W+1){1'b0}}, sb6_ff[SUM_W-1:1]};

   logic             da_v, db_v;
   logic [AMP_W-1:0] qa, qb;
   logic [1:0]       da_side;
   logic             db_side;

   fsdr_div_pipe #(
      .DEN_W (SUM_W),
      .QUO_W (AMP_W),
      .SIDE_W(2)
   ) u_div_par (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (v6_ff),
      .in_num   (num_a),
      .in_den   (sa6_ff),
      .in_side  ({tir6_ff, sa6_ff == '0}),
      .out_valid(da_v),
      .out_quo  (qa),
      .out_side (da_side)
   );

   fsdr_div_pipe #(
      .DEN_W (SUM_W),
      .QUO_W (AMP_W),
      .SIDE_W(1)
   ) u_div_perp (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (v6_ff),
      .in_num   (num_b),
      .in_den   (sb6_ff),
      .in_side  (sb6_ff == '0),
      .out_valid(db_v),
      .out_quo  (qb),
      .out_side (db_side)
   );

   // A zero divisor only occurs at grazing incidence with a zero index: amplitude one.
   logic [AMP_W-1:0] amp_a, amp_b;

   assign amp_a = da_side[0] ? fsdr_pkg::REFL_ONE : qa;
   assign amp_b = db_side ? fsdr_pkg::REFL_ONE : qb;

   // Stage 8: squared amplitudes in Q30.
   logic               v8_ff, tir8_ff;
   logic [2*AMP_W-1:0] aa8_ff, bb8_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         aa8_ff  <= {{AMP_W{1'b0}}, amp_a} * {{AMP_W{1'b0}}, amp_a};
         bb8_ff  <= {{AMP_W{1'b0}}, amp_b} * {{AMP_W{1'b0}}, amp_b};
         tir8_ff <= da_side[1];
      end
   end

   // Output stage: the mean of the squares rounded to Q15, then saturated, or one on total internal reflection.
   logic [2*AMP_W:0]  sum_full;
   logic [AMP_W:0]    sum_q15;
   logic [AMP_W-1:0]  refl_in;
   logic [AMP_W-1:0]  refl_ff;
   logic              tir_ff;

   assign sum_full = {1'b0, aa8_ff} + {1'b0, bb8_ff}
                   + (2*AMP_W+1)'(fsdr_pkg::REFL_ONE);
   assign sum_q15  = sum_full[2*AMP_W:AMP_W];

   always_comb begin
      if (tir8_ff || sum_q15 > {1'b0, fsdr_pkg::REFL_ONE}) begin
         refl_in = fsdr_pkg::REFL_ONE;
      end else begin
         refl_in = sum_q15[AMP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         refl_ff <= refl_in;
         tir_ff  <= tir8_ff;
      end
   end

   // Valid bits of the stages outside the arithmetic units.
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff    <= 1'b0;
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
         v4_ff    <= 1'b0;
         v5_ff    <= 1'b0;
         v6_ff    <= 1'b0;
         v8_ff    <= 1'b0;
         out_v_ff <= 1'b0;
      end else if (en) begin
         v0_ff    <= req_chan.valid;
         v1_ff    <= v0_ff;
         v2_ff    <= v1_ff;
         v3_ff    <= v2_ff;
         v4_ff    <= d1_v;
         v5_ff    <= sq_v;
         v6_ff    <= v5_ff;
         v8_ff    <= da_v && db_v;
         out_v_ff <= v8_ff;
      end
   end

   assign rsp_chan.valid          = out_v_ff;
   assign rsp_chan.reflectance    = refl_ff;
   assign rsp_chan.total_internal = tir_ff;
endmodule

### test/tb_fresnel_dielectric_reflectance.sv
// Self-checking testbench for the dielectric Fresnel reflectance pipeline.
`timescale 1ns / 1ps
module tb_fresnel_dielectric_reflectance;

   // One request as the driver sends it.
   typedef struct packed {
      logic signed [fsdr_pkg::COS_W-1:0] cos_in;
      logic [fsdr_pkg::ETA_W-1:0]        eta_i;
      logic [fsdr_pkg::ETA_W-1:0]        eta_t;
   } fresnel_req_type;

   // One predicted response.
   typedef struct packed {
      logic [fsdr_pkg::REFL_W-1:0] refl;
      logic                        tir;
   } fresnel_rsp_type;

   // The pipeline is 68 stages deep, so the drain wait covers that comfortably.
   localparam int PIPE_DEPTH = 68;
   localparam int RANDOM_ITEMS = 700;

   logic clock;
   logic reset;

   fsdr_req_if req_chan ();
   fsdr_rsp_if rsp_chan ();

   fresnel_dielectric_reflectance DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   fresnel_req_type pending_reqs[$];
   fresnel_rsp_type expected_refl[$];
   int unsigned send_idle_pct;
   int unsigned sink_stall_pct;
   bit hold_sender;
   int unsigned mismatch_count;
   int unsigned transfers_sent;
   int unsigned transfers_checked;
   int unsigned tir_seen;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Integer square root, floor, by the bitwise digit method.
   function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
      logic [63:0] res;
      logic [63:0] bitpos;
      res = 64'd0;
      bitpos = 64'd1 << 62;
      while (bitpos > v) bitpos = bitpos >> 2;
      while (bitpos != 0) begin
         if (v >= res + bitpos) begin
            v = v - (res + bitpos);
            res = (res >> 1) + bitpos;
         end else begin
            res = res >> 1;
         end
         bitpos = bitpos >> 2;
      end
      return res;
   endfunction

   // |x - y| / (x + y) in Q15 rounded to nearest; one when the sum is zero.
   function automatic logic [63:0] amplitude_q15(input logic [63:0] x, input logic [63:0] y);
      logic [63:0] s;
      logic [63:0] d;
      s = x + y;
      d = (x > y) ? x - y : y - x;
      if (s == 0) return 64'd32768;
      return ((d << 15) + (s >> 1)) / s;
   endfunction

   // Computes the expected reflectance and total internal reflection flag.
   function automatic fresnel_rsp_type predict_reflectance(input fresnel_req_type r);
      fresnel_rsp_type o;
      int cs;
      logic [63:0] ei, et, tmp, c, s2, lhs, rhs, ct2, ct, a, b, sum;
      cs = int'($signed(r.cos_in));
      ei = 64'(r.eta_i);
      et = 64'(r.eta_t);
      if (cs > 16384) cs = 16384;
      if (cs < -16384) cs = -16384;
      // A grazing or backward ray comes from the other side of the boundary.
      if (cs <= 0) begin
         tmp = ei;
         ei = et;
         et = tmp;
         cs = -cs;
      end
      c = 64'(cs);
      s2 = (64'd1 << 28) - c * c;
      lhs = ei * ei * s2;
      rhs = (et * et) << 28;
      if (lhs >= rhs) begin
         o.refl = fsdr_pkg::REFL_ONE;
         o.tir = 1'b1;
         return o;
      end
      ct2 = (64'd1 << 28) - lhs / (et * et);
      ct = floor_sqrt(ct2);
      a = amplitude_q15(et * c, ei * ct);
      b = amplitude_q15(ei * c, et * ct);
      sum = (a * a + b * b + 64'd32768) >> 16;
      if (sum > 64'd32768) sum = 64'd32768;
      o.refl = sum[15:0];
      o.tir = 1'b0;
      return o;
   endfunction

   function automatic fresnel_req_type make_req(input int cs, input int ei, input int et);
      fresnel_req_type r;
      r.cos_in = cs[15:0];
      r.eta_i = ei[15:0];
      r.eta_t = et[15:0];
      return r;
   endfunction

   // Appends one request to the tail of the pending queue.
   task automatic queue_req(input int cs, input int ei, input int et);
      pending_reqs.insert(pending_reqs.size(), make_req(cs, ei, et));
   endtask

   // Random index: mostly physical glass-like values, sometimes anything at all.
   function automatic int random_eta();
      case ($urandom_range(0, 9))
         0: return $urandom_range(0, 65535);
         1: return $urandom_range(0, 15);
         2: return $urandom_range(60000, 65535);
         default: return $urandom_range(4096, 12288);
      endcase
   endfunction

   function automatic int random_cos();
      case ($urandom_range(0, 7))
         0: return $urandom_range(0, 65535);
         1: return $urandom_range(16380, 16400);
         2: return -int'($urandom_range(16380, 16400));
         3: return $urandom_range(0, 8) - 4;
         default: return int'($urandom_range(0, 32768)) - 16384;
      endcase
   endfunction

   // Driver: valid stays up until the transfer happens, and the payload is only
   // replaced after an accepted transfer.
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_chan.ready) begin
         if (pending_reqs.size() != 0 && !hold_sender &&
             $urandom_range(0, 99) >= send_idle_pct) begin
            fresnel_req_type r;
            r = pending_reqs.pop_front();
            req_chan.valid <= 1'b1;
            req_chan.cos_incident <= r.cos_in;
            req_chan.eta_incident <= r.eta_i;
            req_chan.eta_transmitted <= r.eta_t;
            expected_refl.insert(expected_refl.size(), predict_reflectance(r));
            transfers_sent <= transfers_sent + 1;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // Monitor: checks each response transfer against the oldest prediction and
   // re-rolls the backpressure every cycle.
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
         if (rsp_chan.valid && rsp_chan.ready) begin
            transfers_checked <= transfers_checked + 1;
            if (expected_refl.size() == 0) begin
               mismatch_count = mismatch_count + 1;
               if (mismatch_count <= 10)
                  $display("ERROR: unexpected response refl=%0d tir=%0b",
                           rsp_chan.reflectance, rsp_chan.total_internal);
            end else begin
               fresnel_rsp_type e;
               e = expected_refl.pop_front();
               if (e.refl !== rsp_chan.reflectance || e.tir !== rsp_chan.total_internal) begin
                  mismatch_count = mismatch_count + 1;
                  if (mismatch_count <= 10)
                     $display("ERROR: response %0d expected refl=%0d tir=%0b got refl=%0d tir=%0b",
                              transfers_checked, e.refl, e.tir,
                              rsp_chan.reflectance, rsp_chan.total_internal);
               end
               if (e.tir) tir_seen <= tir_seen + 1;
            end
         end
      end
   end

   // Waits until the queues are empty, no request is up, and every prediction has been checked.
   task automatic wait_for_drain();
      while (pending_reqs.size() != 0 || req_chan.valid || expected_refl.size() != 0)
         @(posedge clock);
   endtask

   initial begin
      int phase;
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.cos_incident = '0;
      req_chan.eta_incident = '0;
      req_chan.eta_transmitted = '0;
      rsp_chan.ready = 1'b0;
      send_idle_pct = 0;
      sink_stall_pct = 0;
      hold_sender = 1'b0;
      mismatch_count = 0;
      transfers_sent = 0;
      transfers_checked = 0;
      tir_seen = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed items: cosine extremes and clamping, the zero cosine swap,
      // a zero transmitted index, grazing incidence with a zero incident index,
      // normal incidence, and total internal reflection from the dense side.
      queue_req(16384, 4096, 6144);
      queue_req(32767, 4096, 6144);
      queue_req(-32768, 4096, 6144);
      queue_req(-16384, 6144, 4096);
      queue_req(0, 4096, 6144);
      queue_req(0, 6144, 4096);
      queue_req(1, 4096, 6144);
      queue_req(-1, 4096, 6144);
      queue_req(8192, 4096, 0);
      queue_req(-8192, 0, 4096);
      queue_req(1, 0, 4096);
      queue_req(1, 0, 0);
      queue_req(0, 0, 0);
      queue_req(16384, 4096, 4096);
      queue_req(4000, 6144, 4096);
      queue_req(12000, 6144, 4096);
      queue_req(16384, 65535, 1);
      queue_req(16384, 1, 65535);
      queue_req(100, 65535, 65535);
      queue_req(16383, 65535, 65534);
      queue_req(-16383, 21845, 43690);
      queue_req(10922, 43690, 21845);

      // Keep the sender quiet right after reset, then let the
      // directed items go and wait until all of their responses are in.
      hold_sender = 1'b1;
      repeat (5) @(posedge clock);
      hold_sender = 1'b0;
      wait_for_drain();

      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  sink_stall_pct = 0;  end
            1: begin send_idle_pct = 81; sink_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  sink_stall_pct = 81; end
            default: begin send_idle_pct = 12; sink_stall_pct = 12; end
         endcase
         repeat (RANDOM_ITEMS / 4)
            queue_req(random_cos(), random_eta(), random_eta());
         wait_for_drain();
      end

      repeat (PIPE_DEPTH + 20) @(posedge clock);
      $display("Covered %0d request transfers and %0d response transfers, %0d of them with",
               transfers_sent, transfers_checked, tir_seen);
      $display("total internal reflection, over four idle and stall phases.");
      if (mismatch_count == 0 && expected_refl.size() == 0) begin
         $display("PASS fresnel_dielectric_reflectance");
      end else begin
         $display("FAIL fresnel_dielectric_reflectance");
      end
      $finish;
   end

   // Watchdog: well beyond the slowest legal run under the heaviest stalls.
   initial begin
      #5ms;
      $display("FAIL fresnel_dielectric_reflectance");
      $finish;
   end
endmodule
